// ----- hw/rtl/pwm_pkg.sv -----
// Package for the peak window mean block: item and result types,
// sequencer states, command codes and fixed field widths.
// No dependencies.
package pwm_pkg;

  localparam int AXES     = 3;
  localparam int AXIS_W   = 2;
  localparam int SAMPLE_W = 14;
  localparam int PEAK_W   = 15;
  localparam int MEAN_W   = 12;
  localparam int SPP_W    = 8;
  localparam int MODE_W   = 2;

  localparam logic [MEAN_W-1:0] MEAN_MAX = {MEAN_W{1'b1}};
  localparam logic [SPP_W-1:0]  SPP_RESET = 8'd20;

  typedef enum logic [MODE_W-1:0] {
    MODE_SAMPLE    = 2'd0,
    MODE_CLR_PEAKS = 2'd1,
    MODE_CLR_OFFS  = 2'd2,
    MODE_CALIBRATE = 2'd3
  } pwm_mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SAMPLE,
    ST_COUNT,
    ST_CAL_DIV,
    ST_CAL_WAIT,
    ST_RING_RD,
    ST_RING_UPD,
    ST_MEAN_WAIT,
    ST_DONE
  } pwm_state_t;

  typedef struct packed {
    logic [MODE_W-1:0]                  mode;
    logic [AXES-1:0][SAMPLE_W-1:0]      smp;   // index 0 = X
  } pwm_item_t;

  typedef struct packed {
    logic [AXES-1:0][MEAN_W-1:0] mean;         // per axis, index 0 = X
    logic                        closed;
    logic                        calib;
  } pwm_result_t;

endpackage

// ----- hw/rtl/pwm_div.sv -----
// Restoring divider, one quotient bit per cycle, shared by the sequencer
// for calibration offsets and window means. Depends on nothing.
module pwm_div #(
  parameter int DD_W = 21,
  parameter int DV_W = 7
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [DD_W-1:0] dividend,
  input  logic [DV_W-1:0] divisor,
  output logic            done,
  output logic [DD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DD_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DV_W-1:0]  rem_r, rem_nxt;
  logic [DD_W-1:0]  quo_r, quo_nxt;
  logic [DV_W-1:0]  dvs_r, dvs_nxt;
  logic [DV_W:0]    trial;
  logic [DV_W:0]    diff;
  logic             ge;

  always_comb begin
    trial    = {rem_r, quo_r[DD_W-1]};
    diff     = trial - {1'b0, dvs_r};
    ge       = trial >= {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DD_W);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DV_W-1:0] : trial[DV_W-1:0];
      quo_nxt = {quo_r[DD_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- hw/rtl/pwm_ring.sv -----
// Peak ring memory, all axes in one array, one write and one registered
// read port. Depends on nothing.
module pwm_ring #(
  parameter int DEPTH = 30,
  parameter int AW    = 5,
  parameter int DW    = 15
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hw/rtl/pwm_seq.sv -----
// Sequencer and state of the peak window mean block: per-axis peak update,
// calibration and ring update, one axis at a time over the shared divider.
// Depends on pwm_pkg, pwm_div and pwm_ring.
module pwm_seq
  import pwm_pkg::*;
#(
  parameter int WINDOW_DEPTH  = 10,
  parameter int CALIB_SAMPLES = 100,
  parameter int MEAN_DIVISOR  = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  pwm_item_t        item,
  input  logic [SPP_W-1:0] spp,
  output logic             idle,
  output logic             res_valid,
  input  logic             res_take,
  output pwm_result_t      result
);

  localparam int RP_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int RSUM_W = PEAK_W + $clog2(WINDOW_DEPTH + 1);
  localparam int CCNT_W = $clog2(CALIB_SAMPLES + 1);
  localparam int CSUM_W = SAMPLE_W + $clog2(CALIB_SAMPLES + 1);
  localparam int MDV    = WINDOW_DEPTH * MEAN_DIVISOR;
  localparam int DVA_W  = $clog2(MDV + 1);
  localparam int DVB_W  = $clog2(CALIB_SAMPLES + 1);
  localparam int DV_W   = (DVA_W > DVB_W) ? DVA_W : DVB_W;
  localparam int DD_W   = (RSUM_W > CSUM_W) ? RSUM_W : CSUM_W;
  localparam int MEM_D  = AXES * WINDOW_DEPTH;
  localparam int MA_W   = $clog2(MEM_D);

  pwm_state_t state_r, state_nxt;
  logic [AXIS_W-1:0]                 axis_r, axis_nxt;
  pwm_item_t                         item_r, item_nxt;
  logic [AXES-1:0][SAMPLE_W-1:0]     offset_r, offset_nxt;
  logic [AXES-1:0][PEAK_W-1:0]       peak_r, peak_nxt;
  logic [AXES-1:0][RSUM_W-1:0]       rsum_r, rsum_nxt;
  logic [AXES-1:0][CSUM_W-1:0]       csum_r, csum_nxt;
  logic [AXES-1:0][MEAN_W-1:0]       mean_r, mean_nxt;
  logic [RP_W-1:0]                   pos_r, pos_nxt;
  logic [FILL_W-1:0]                 fill_r, fill_nxt;
  logic [SPP_W-1:0]                  scnt_r, scnt_nxt;
  logic [CCNT_W-1:0]                 ccnt_r, ccnt_nxt;
  logic                              cact_r, cact_nxt;
  logic                              closed_r, closed_nxt;
  logic                              win_r, win_nxt;

  logic signed [SAMPLE_W-1:0] raw;
  logic signed [SAMPLE_W+1:0] v_s;
  logic [PEAK_W-1:0]          v_mag;
  logic [SPP_W-1:0]           scnt_inc;
  logic [CCNT_W-1:0]          ccnt_inc;
  logic                       cal_end;
  logic                       win_hit;
  logic                       ring_full;
  logic [FILL_W-1:0]          fill_new;
  logic [PEAK_W-1:0]          old_peak;
  logic [RSUM_W-1:0]          rsum_new;
  logic                       cneg;
  logic [CSUM_W-1:0]          cmag;
  logic [SAMPLE_W-1:0]        qoff;

  logic            div_start;
  logic [DD_W-1:0] div_dvd;
  logic [DV_W-1:0] div_dvs;
  logic            div_done;
  logic [DD_W-1:0] div_q;

  logic            mem_wr, mem_rd;
  logic [MA_W-1:0] mem_addr;
  logic [PEAK_W-1:0] mem_rdata;

  pwm_div #(.DD_W(DD_W), .DV_W(DV_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  pwm_ring #(.DEPTH(MEM_D), .AW(MA_W), .DW(PEAK_W)) u_ring (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (mem_addr),
    .wr_data (peak_r[axis_r]),
    .rd_en   (mem_rd),
    .rd_addr (mem_addr),
    .rd_data (mem_rdata)
  );

  always_comb begin
    raw       = $signed(item_r.smp[axis_r]);
    v_s       = cact_r ? (SAMPLE_W+2)'(raw)
                       : (SAMPLE_W+2)'(raw) - (SAMPLE_W+2)'($signed(offset_r[axis_r]));
    v_mag     = v_s[SAMPLE_W+1] ? '0 : v_s[PEAK_W-1:0];
    scnt_inc  = scnt_r + 1'b1;
    ccnt_inc  = ccnt_r + 1'b1;
    cal_end   = cact_r && (ccnt_inc >= CCNT_W'(CALIB_SAMPLES));
    win_hit   = scnt_inc >= spp;
    ring_full = fill_r == FILL_W'(WINDOW_DEPTH);
    fill_new  = ring_full ? fill_r : fill_r + 1'b1;
    old_peak  = ring_full ? mem_rdata : '0;
    rsum_new  = rsum_r[axis_r] - RSUM_W'(old_peak) + RSUM_W'(peak_r[axis_r]);
    cneg      = csum_r[axis_r][CSUM_W-1];
    cmag      = cneg ? -csum_r[axis_r] : csum_r[axis_r];
    qoff      = cneg ? -div_q[SAMPLE_W-1:0] : div_q[SAMPLE_W-1:0];
    mem_addr  = MA_W'(axis_r) * MA_W'(WINDOW_DEPTH) + MA_W'(pos_r);

    state_nxt  = state_r;
    axis_nxt   = axis_r;
    item_nxt   = item_r;
    offset_nxt = offset_r;
    peak_nxt   = peak_r;
    rsum_nxt   = rsum_r;
    csum_nxt   = csum_r;
    mean_nxt   = mean_r;
    pos_nxt    = pos_r;
    fill_nxt   = fill_r;
    scnt_nxt   = scnt_r;
    ccnt_nxt   = ccnt_r;
    cact_nxt   = cact_r;
    closed_nxt = closed_r;
    win_nxt    = win_r;
    div_start  = 1'b0;
    div_dvd    = DD_W'(cmag);
    div_dvs    = DV_W'(CALIB_SAMPLES);
    mem_wr     = 1'b0;
    mem_rd     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          item_nxt   = item;
          closed_nxt = 1'b0;
          axis_nxt   = '0;
          unique case (pwm_mode_t'(item.mode))
            MODE_SAMPLE: begin
              state_nxt = ST_SAMPLE;
            end
            MODE_CLR_PEAKS: begin
              peak_nxt  = '0;
              state_nxt = ST_DONE;
            end
            MODE_CLR_OFFS: begin
              peak_nxt   = '0;
              cact_nxt   = 1'b0;
              ccnt_nxt   = '0;
              csum_nxt   = '0;
              offset_nxt = '0;
              state_nxt  = ST_DONE;
            end
            MODE_CALIBRATE: begin
              peak_nxt  = '0;
              cact_nxt  = 1'b1;
              ccnt_nxt  = '0;
              csum_nxt  = '0;
              state_nxt = ST_DONE;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_SAMPLE: begin
        if (cact_r) begin
          csum_nxt[axis_r] = csum_r[axis_r] + CSUM_W'(raw);
        end
        if (v_mag > peak_r[axis_r]) begin
          peak_nxt[axis_r] = v_mag;
        end
        if (axis_r == AXIS_W'(AXES - 1)) begin
          axis_nxt  = '0;
          state_nxt = ST_COUNT;
        end else begin
          axis_nxt = axis_r + 1'b1;
        end
      end
      ST_COUNT: begin
        if (cact_r) begin
          ccnt_nxt = cal_end ? '0 : ccnt_inc;
        end
        if (cal_end) begin
          cact_nxt = 1'b0;
        end
        scnt_nxt = win_hit ? '0 : scnt_inc;
        win_nxt  = win_hit;
        priority if (cal_end) begin
          state_nxt = ST_CAL_DIV;
        end else if (win_hit) begin
          state_nxt = ST_RING_RD;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_CAL_DIV: begin
        div_start = 1'b1;
        state_nxt = ST_CAL_WAIT;
      end
      ST_CAL_WAIT: begin
        if (div_done) begin
          offset_nxt[axis_r] = qoff;
          csum_nxt[axis_r]   = '0;
          if (axis_r == AXIS_W'(AXES - 1)) begin
            axis_nxt  = '0;
            state_nxt = win_r ? ST_RING_RD : ST_DONE;
          end else begin
            axis_nxt  = axis_r + 1'b1;
            state_nxt = ST_CAL_DIV;
          end
        end
      end
      ST_RING_RD: begin
        mem_rd    = 1'b1;
        state_nxt = ST_RING_UPD;
      end
      ST_RING_UPD: begin
        mem_wr           = 1'b1;
        rsum_nxt[axis_r] = rsum_new;
        div_start        = 1'b1;
        div_dvd          = DD_W'(rsum_new);
        div_dvs          = DV_W'(fill_new) * DV_W'(MEAN_DIVISOR);
        state_nxt        = ST_MEAN_WAIT;
      end
      ST_MEAN_WAIT: begin
        if (div_done) begin
          mean_nxt[axis_r] = (div_q > DD_W'(MEAN_MAX)) ? MEAN_MAX : div_q[MEAN_W-1:0];
          if (axis_r == AXIS_W'(AXES - 1)) begin
            axis_nxt   = '0;
            pos_nxt    = (pos_r == RP_W'(WINDOW_DEPTH - 1)) ? '0 : pos_r + 1'b1;
            fill_nxt   = fill_new;
            peak_nxt   = '0;
            closed_nxt = 1'b1;
            win_nxt    = 1'b0;
            state_nxt  = ST_DONE;
          end else begin
            axis_nxt  = axis_r + 1'b1;
            state_nxt = ST_RING_RD;
          end
        end
      end
      ST_DONE: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r   <= '0;
      offset_r <= '0;
      peak_r   <= '0;
      rsum_r   <= '0;
      csum_r   <= '0;
      mean_r   <= '0;
      pos_r    <= '0;
      fill_r   <= '0;
      scnt_r   <= '0;
      ccnt_r   <= '0;
      cact_r   <= 1'b0;
      closed_r <= 1'b0;
      win_r    <= 1'b0;
    end else begin
      axis_r   <= axis_nxt;
      offset_r <= offset_nxt;
      peak_r   <= peak_nxt;
      rsum_r   <= rsum_nxt;
      csum_r   <= csum_nxt;
      mean_r   <= mean_nxt;
      pos_r    <= pos_nxt;
      fill_r   <= fill_nxt;
      scnt_r   <= scnt_nxt;
      ccnt_r   <= ccnt_nxt;
      cact_r   <= cact_nxt;
      closed_r <= closed_nxt;
      win_r    <= win_nxt;
    end
    item_r <= item_nxt;
  end

  assign idle          = state_r == ST_IDLE;
  assign res_valid     = state_r == ST_DONE;
  assign result.mean   = mean_r;
  assign result.closed = closed_r;
  assign result.calib  = cact_r;

endmodule

// ----- hw/rtl/axis_peak_window_mean.sv -----
// Top level of the peak window mean block: stream ports, window length
// register and output register. Depends on pwm_pkg and pwm_seq.
//
//  channel  ports                               item
//  input    in_tvalid/in_tready/in_tdata/tuser  mode + X, Y, Z sample
//  output   out_tvalid/out_tready/out_tdata/tuser  Y, X, Z means + flags
//  config   cfg_wr_en/cfg_wr_data               samples_per_peak
//
// Sample item: 3 axis steps in one shared datapath, then count and result.
// Command item: result only. Window close adds ring read, ring update and mean
// divide per axis; calibration end adds an offset divide per axis (bit-serial
// divider, width DD = 21 by default). in_tready is low from accept until the
// result moves to the output register, which holds while out_tready is low.
// Reset is synchronous; item, output data, divider datapath and ring not cleared.
module axis_peak_window_mean
  import pwm_pkg::*;
#(
  parameter int WINDOW_DEPTH  = 10,
  parameter int CALIB_SAMPLES = 100,
  parameter int MEAN_DIVISOR  = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [47:0]      in_tdata,    // sample_x, sample_y, sample_z, zero pad
  input  logic [1:0]       in_tuser,    // mode
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [39:0]      out_tdata,   // mean_first, mean_second, mean_third, pad
  output logic [1:0]       out_tuser,   // window_closed, calibrating
  input  logic             cfg_wr_en,
  input  logic [SPP_W-1:0] cfg_wr_data
);

  logic [SPP_W-1:0] spp_r, spp_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [39:0]      out_data_r, out_data_nxt;
  logic [1:0]       out_user_r, out_user_nxt;

  pwm_item_t   item;
  pwm_result_t result;
  logic        seq_idle;
  logic        res_valid;
  logic        res_take;
  logic        start;

  assign item.mode   = in_tuser;
  assign item.smp[0] = in_tdata[13:0];
  assign item.smp[1] = in_tdata[27:14];
  assign item.smp[2] = in_tdata[41:28];
  assign in_tready   = seq_idle;
  assign start       = in_tvalid && seq_idle;
  assign res_take    = !out_valid_r || out_tready;

  pwm_seq #(
    .WINDOW_DEPTH  (WINDOW_DEPTH),
    .CALIB_SAMPLES (CALIB_SAMPLES),
    .MEAN_DIVISOR  (MEAN_DIVISOR)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .item      (item),
    .spp       (spp_r),
    .idle      (seq_idle),
    .res_valid (res_valid),
    .res_take  (res_take),
    .result    (result)
  );

  always_comb begin
    spp_nxt       = cfg_wr_en ? cfg_wr_data : spp_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    if (res_valid && res_take) begin
      out_valid_nxt = 1'b1;
      // X and Y leave swapped
      out_data_nxt  = {4'd0, result.mean[2], result.mean[0], result.mean[1]};
      out_user_nxt  = {result.calib, result.closed};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spp_r       <= SPP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      spp_r       <= spp_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ----- hw/rtl/pwm_check.sv -----
// Port-level checker for axis_peak_window_mean, bound to the top level.
// Watches only the stream handshakes and the output item; no dependencies.
module pwm_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [1:0]  out_tuser
);

  logic [1:0] cnt_r, cnt_nxt;
  logic       in_acc, out_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc && !out_acc) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (out_acc && !in_acc) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled output item changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("input taken again before item finished");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> cnt_r != 2'd0)
    else $error("output item without an accepted input item");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("more than two items in flight");

endmodule

bind axis_peak_window_mean pwm_check u_pwm_check (.*);
